// ----- hw/rtl/tps_pkg.sv -----
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants of the trilinear prolongation stream
// Widths of the stream words, register indexes and the queue entry format.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int MAX_EXTENT_DEFAULT = 64;

  localparam int VALUE_W     = 32;
  localparam int FINE_W      = 7;
  localparam int COORD_KEEP  = FINE_W - 1;   // low coordinate bits that reach a fine index
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int S_TDATA_W   = 32;
  localparam int M_TDATA_W   = 56;           // 53 payload bits padded to whole bytes
  localparam int QUEUE_DEPTH = 2;

  // Bit positions of the result word
  localparam int FX_LSB   = 0;
  localparam int FY_LSB   = FX_LSB + FINE_W;
  localparam int FZ_LSB   = FY_LSB + FINE_W;
  localparam int CORR_LSB = FZ_LSB + FINE_W;

  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z = 2'd2;

  // One coarse sample with its 2x2x2 neighborhood; val index is {dx, dy, dz}
  // where a set bit means one step back along that axis.
  typedef struct packed {
    logic [7:0][VALUE_W-1:0] val;
    logic [COORD_KEEP-1:0]   cx;
    logic [COORD_KEEP-1:0]   cy;
    logic [COORD_KEEP-1:0]   cz;
    logic                    hx;   // coarse x index above zero
    logic                    hy;
    logic                    hz;
  } item_t;

  typedef struct packed {
    logic ax;   // 0: midpoint below, 1: coarse point
    logic ay;
    logic az;
  } combo_t;

endpackage

// ----- hw/rtl/tps_ram.sv -----
// ----------------------------------------------------------------------------
// tps_ram: generic RAM, one write port, two registered read ports
// Read data updates only on a read enable and holds otherwise.
// ----------------------------------------------------------------------------
module tps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- hw/rtl/tps_front.sv -----
// ----------------------------------------------------------------------------
// tps_front: input side of the prolongation stream
// Tracks the coarse position, writes each word to the plane banks, reads the
// three stored neighbors and builds the 2x2x2 neighborhood for the queue.
// ----------------------------------------------------------------------------
module tps_front #(
  parameter int MAX_EXTENT = tps_pkg::MAX_EXTENT_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [tps_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input  logic                           cfg_valid,
  input  logic [tps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           q_full,
  output logic                           q_push,
  output tps_pkg::item_t                 q_item
);

  localparam int PW        = (MAX_EXTENT > 1) ? $clog2(MAX_EXTENT) : 1;
  localparam int EW        = $clog2(MAX_EXTENT + 1);
  localparam int AW        = 2 * PW;
  localparam int BANK_D    = 1 << AW;
  localparam int EXT_RESET = (MAX_EXTENT < 64) ? MAX_EXTENT : 64;
  localparam int VW        = tps_pkg::VALUE_W;
  localparam int CK        = tps_pkg::COORD_KEEP;

  logic [EW-1:0] ext_x, ext_y, ext_z;
  logic [PW-1:0] pos_x, pos_y, pos_z;
  logic [PW-1:0] pos_x_next, pos_y_next, pos_z_next;
  logic [EW-1:0] x_inc, y_inc, z_inc;
  logic [EW-1:0] cfg_ext;
  logic [31:0]   cfg_wide;
  logic          in_acc;
  logic          cfg_hit;

  logic [PW-1:0] y_dn;
  logic [AW-1:0] addr_here, addr_up;
  logic          bank0_sel, bank1_sel;
  logic [VW-1:0] b0_qa, b0_qb, b1_qa, b1_qb;

  logic          s1_v;
  logic [VW-1:0] s1_val;
  logic          s1_par;
  logic [CK-1:0] s1_cx, s1_cy, s1_cz;
  logic          s1_hx, s1_hy, s1_hz;
  logic [3:0][VW-1:0] prev;   // z-front of the previous word, index {dx, dy}
  logic [3:0][VW-1:0] front;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign q_push        = s1_v && !q_full;
  assign s_axis_tready = !s1_v || !q_full;

  // Clamp the written extent into 1..MAX_EXTENT
  assign cfg_wide = 32'(cfg_data);
  assign cfg_ext  = (cfg_wide == 32'd0) ? EW'(1) :
                    (cfg_wide > 32'(MAX_EXTENT)) ? EW'(MAX_EXTENT) : EW'(cfg_wide);

  always_comb begin
    cfg_hit = 1'b0;
    unique case (cfg_index) inside
      tps_pkg::REG_EXTENT_X,
      tps_pkg::REG_EXTENT_Y,
      tps_pkg::REG_EXTENT_Z: cfg_hit = cfg_valid;
      default:               cfg_hit = 1'b0;
    endcase
  end

  // Raster advance: z fastest, then y, then x
  assign z_inc = EW'(pos_z) + EW'(1);
  assign y_inc = EW'(pos_y) + EW'(1);
  assign x_inc = EW'(pos_x) + EW'(1);

  always_comb begin
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    pos_z_next = PW'(z_inc);
    if (z_inc >= ext_z) begin
      pos_z_next = '0;
      pos_y_next = PW'(y_inc);
      if (y_inc >= ext_y) begin
        pos_y_next = '0;
        pos_x_next = (x_inc >= ext_x) ? '0 : PW'(x_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_x <= EW'(EXT_RESET);
      ext_y <= EW'(EXT_RESET);
      ext_z <= EW'(EXT_RESET);
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        tps_pkg::REG_EXTENT_X: ext_x <= cfg_ext;
        tps_pkg::REG_EXTENT_Y: ext_y <= cfg_ext;
        tps_pkg::REG_EXTENT_Z: ext_z <= cfg_ext;
        default: ;
      endcase
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (in_acc) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      pos_z <= pos_z_next;
    end
  end

  // Bank by x parity: current plane gets the write and the row-above read,
  // the other plane serves both reads of the previous x.
  assign y_dn      = pos_y - PW'(1);
  assign addr_here = {pos_y, pos_z};
  assign addr_up   = {y_dn, pos_z};
  assign bank0_sel = !pos_x[0];
  assign bank1_sel = pos_x[0];

  tps_ram #(.WIDTH(VW), .DEPTH(BANK_D)) u_bank0 (
    .clk     (clk),
    .we      (in_acc && bank0_sel),
    .waddr   (addr_here),
    .wdata   (s_axis_tdata[VW-1:0]),
    .re      (in_acc),
    .raddr_a (bank0_sel ? addr_up : addr_here),
    .raddr_b (addr_up),
    .rdata_a (b0_qa),
    .rdata_b (b0_qb)
  );

  tps_ram #(.WIDTH(VW), .DEPTH(BANK_D)) u_bank1 (
    .clk     (clk),
    .we      (in_acc && bank1_sel),
    .waddr   (addr_here),
    .wdata   (s_axis_tdata[VW-1:0]),
    .re      (in_acc),
    .raddr_a (bank1_sel ? addr_up : addr_here),
    .raddr_b (addr_up),
    .rdata_a (b1_qa),
    .rdata_b (b1_qb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_acc) begin
      s1_v <= 1'b1;
    end else if (q_push) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_val <= s_axis_tdata[VW-1:0];
      s1_par <= pos_x[0];
      s1_cx  <= CK'(pos_x);
      s1_cy  <= CK'(pos_y);
      s1_cz  <= CK'(pos_z);
      s1_hx  <= (pos_x != '0);
      s1_hy  <= (pos_y != '0);
      s1_hz  <= (pos_z != '0);
    end
  end

  always_comb begin
    front[0] = s1_val;
    front[1] = s1_par ? b1_qa : b0_qa;   // (x, y-1)
    front[2] = s1_par ? b0_qa : b1_qa;   // (x-1, y)
    front[3] = s1_par ? b0_qb : b1_qb;   // (x-1, y-1)
  end

  // Hold the z-front for the next word, which sits one step further in z
  always_ff @(posedge clk) begin
    if (q_push) begin
      prev <= front;
    end
  end

  always_comb begin
    q_item.val[0] = front[0];
    q_item.val[1] = prev[0];
    q_item.val[2] = front[1];
    q_item.val[3] = prev[1];
    q_item.val[4] = front[2];
    q_item.val[5] = prev[2];
    q_item.val[6] = front[3];
    q_item.val[7] = prev[3];
    q_item.cx     = s1_cx;
    q_item.cy     = s1_cy;
    q_item.cz     = s1_cz;
    q_item.hx     = s1_hx;
    q_item.hy     = s1_hy;
    q_item.hz     = s1_hz;
  end

endmodule

// ----- hw/rtl/tps_queue.sv -----
// ----------------------------------------------------------------------------
// tps_queue: short queue between front and back
// Holds built neighborhoods so each side can stall on its own.
// ----------------------------------------------------------------------------
module tps_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tps_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output tps_pkg::item_t head
);

  localparam int D   = tps_pkg::QUEUE_DEPTH;
  localparam int QAW = (D > 1) ? $clog2(D) : 1;
  localparam int QCW = $clog2(D + 1);

  tps_pkg::item_t entry [D];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QCW-1:0] count;

  assign full  = (count == QCW'(D));
  assign valid = (count != '0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(D - 1)) ? '0 : wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(D - 1)) ? '0 : rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + QCW'(1);
      end else if (pop && !push) begin
        count <= count - QCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- hw/rtl/tps_back.sv -----
// ----------------------------------------------------------------------------
// tps_back: result side of the prolongation stream
// Walks the fine points of the head neighborhood, one per cycle while not stalled,
// through a three-stage adder pipeline (z pairs, y pairs, x pair plus mean shift).
// ----------------------------------------------------------------------------
module tps_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  tps_pkg::item_t                q_head,
  output logic                          q_pop,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tps_pkg::M_TDATA_W-1:0] m_axis_tdata,   // fine_x, fine_y, fine_z, correction
  output logic                          m_axis_tlast
);

  localparam int VW = tps_pkg::VALUE_W;
  localparam int FW = tps_pkg::FINE_W;

  logic            en;
  logic            fire;
  logic            init;
  tps_pkg::combo_t combo, cur, start, combo_next;
  logic            cur_last;
  logic            dz;

  logic                 p1_v;
  logic signed [VW:0]   p1_c [4];    // index {dx, dy}
  logic                 p1_dx, p1_dy;
  logic [1:0]           p1_k;
  logic [FW-1:0]        p1_fx, p1_fy, p1_fz;
  logic                 p1_last;

  logic                 p2_v;
  logic signed [VW+1:0] p2_r [2];    // index dx
  logic                 p2_dx;
  logic [1:0]           p2_k;
  logic [FW-1:0]        p2_fx, p2_fy, p2_fz;
  logic                 p2_last;

  logic signed [VW+2:0] total;
  logic signed [VW+2:0] mean;

  logic [FW-1:0] o_fx, o_fy, o_fz;
  logic [VW-1:0] o_corr;

  // Advance the whole pipeline unless the output word is stalled
  assign en    = !m_axis_tvalid || m_axis_tready;
  assign fire  = en && q_valid;

  assign start.ax = !q_head.hx;
  assign start.ay = !q_head.hy;
  assign start.az = !q_head.hz;
  assign cur      = init ? start : combo;
  assign cur_last = cur.ax && cur.ay && cur.az;
  assign q_pop    = fire && cur_last;
  assign dz       = !cur.az;

  always_comb begin
    if (!cur.az) begin
      combo_next = '{ax: cur.ax, ay: cur.ay, az: 1'b1};
    end else if (!cur.ay) begin
      combo_next = '{ax: cur.ax, ay: 1'b1, az: start.az};
    end else begin
      combo_next = '{ax: 1'b1, ay: start.ay, az: start.az};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init <= 1'b1;
    end else if (fire) begin
      init <= cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !cur_last) begin
      combo <= combo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v          <= 1'b0;
      p2_v          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      p1_v          <= q_valid;
      p2_v          <= p1_v;
      m_axis_tvalid <= p2_v;
    end
  end

  // Stage 1: sum along z
  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 4; n++) begin
        p1_c[n] <= (VW+1)'($signed(q_head.val[2*n])) +
                   (dz ? (VW+1)'($signed(q_head.val[2*n+1])) : '0);
      end
      p1_dx   <= !cur.ax;
      p1_dy   <= !cur.ay;
      p1_k    <= 2'(!cur.ax) + 2'(!cur.ay) + 2'(dz);
      p1_fx   <= FW'({q_head.cx, cur.ax});
      p1_fy   <= FW'({q_head.cy, cur.ay});
      p1_fz   <= FW'({q_head.cz, cur.az});
      p1_last <= cur_last;
    end
  end

  // Stage 2: sum along y
  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 2; n++) begin
        p2_r[n] <= (VW+2)'(p1_c[2*n]) + (p1_dy ? (VW+2)'(p1_c[2*n+1]) : '0);
      end
      p2_dx   <= p1_dx;
      p2_k    <= p1_k;
      p2_fx   <= p1_fx;
      p2_fy   <= p1_fy;
      p2_fz   <= p1_fz;
      p2_last <= p1_last;
    end
  end

  // Stage 3: sum along x, then floor division by the neighbor count
  assign total = (VW+3)'(p2_r[0]) + (p2_dx ? (VW+3)'(p2_r[1]) : '0);
  assign mean  = total >>> p2_k;

  always_ff @(posedge clk) begin
    if (en) begin
      o_fx         <= p2_fx;
      o_fy         <= p2_fy;
      o_fz         <= p2_fz;
      o_corr       <= mean[VW-1:0];
      m_axis_tlast <= p2_last;
    end
  end

  assign m_axis_tdata = {(tps_pkg::M_TDATA_W - tps_pkg::CORR_LSB - VW)'(0),
                         o_corr, o_fz, o_fy, o_fx};

endmodule

// ----- hw/rtl/trilinear_prolongation_stream.sv -----
// ----------------------------------------------------------------------------
// trilinear_prolongation_stream: 2x trilinear prolongation of a coarse stream
// Coarse samples in raster order in, interpolated fine-grid points out.
// ----------------------------------------------------------------------------
//   channel  | direction | word                                  | accepted when
//   s_axis   | in        | coarse_value                          | tvalid & tready
//   m_axis   | out       | fine_x, fine_y, fine_z, correction;   | tvalid & tready
//            |           | tlast = last result of a sample       |
//   cfg      | in        | cfg_index (extent x/y/z), cfg_data    | cfg_valid & cfg_ready
//
// A sample yields 1 to 8 results (8 away from the low faces), one per cycle
// while m_axis_tready does not stall the output; the result port sets the rate.
// The front takes a word every cycle while its stage and the two-entry queue
// have room; m_axis_tready low freezes only the result pipeline.
// Reset clears the position and sets each extent to MAX_EXTENT (at most 64);
// plane banks are not cleared; only words written by earlier samples of the region are used.
// ----------------------------------------------------------------------------
module trilinear_prolongation_stream #(
  parameter int MAX_EXTENT = tps_pkg::MAX_EXTENT_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [tps_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // coarse_value
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [tps_pkg::M_TDATA_W-1:0]  m_axis_tdata,   // fine_x, fine_y, fine_z, correction
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tps_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic           q_push, q_full, q_pop, q_valid;
  tps_pkg::item_t q_in, q_head;

  assign cfg_ready = 1'b1;

  tps_front #(.MAX_EXTENT(MAX_EXTENT)) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in)
  );

  tps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  tps_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- hw/rtl/tps_checker.sv -----
// ----------------------------------------------------------------------------
// tps_checker: port-level checks of the prolongation stream
// Watches the stream ports and flags results that break handshake and ordering rules.
// ----------------------------------------------------------------------------
module tps_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tps_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);

  logic [7:0] pending;   // samples taken whose final result is not yet out
  logic       in_acc, out_done;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_done = m_axis_tvalid && m_axis_tready && m_axis_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_done) begin
      pending <= pending + 8'd1;
    end else if (out_done && !in_acc) begin
      pending <= pending - 8'd1;
    end
  end

  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_hold_data : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // The final result of a sample is the coarse point itself: all indexes odd
  a_last_odd : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tdata[tps_pkg::FX_LSB] && m_axis_tdata[tps_pkg::FY_LSB] &&
      m_axis_tdata[tps_pkg::FZ_LSB])
    else $error("final result of a sample is not a coarse point");

  a_no_orphan : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != 8'd0)
    else $error("result word without a pending sample");

endmodule

bind trilinear_prolongation_stream tps_checker u_tps_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- bench/tb_trilinear_prolongation_stream.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trilinear_prolongation_stream: self-checking bench for the 2x prolongation
// Streams coarse samples under several region extents and random flow control.
// Every accepted word is run through a local interpolator. Each fine point that
// comes out is compared field by field against the oldest point predicted.
// ----------------------------------------------------------------------------
module tb_trilinear_prolongation_stream;
  import tps_pkg::*;

  localparam int MAX_EXTENT  = MAX_EXTENT_DEFAULT;
  localparam int STORE_WORDS = 2 * MAX_EXTENT * MAX_EXTENT;
  localparam int DRAIN_QUIET = 12;
  localparam int HOLD_AT     = 250;
  localparam int LONG_HOLD   = 400;

  // Index with no register behind it; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {FEED_SAMPLE, FEED_REG, FEED_DRAIN} feed_kind_e;

  typedef struct {
    feed_kind_e           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [VALUE_W-1:0]   word;
  } feed_item_t;

  typedef struct {
    logic [FINE_W-1:0]  fx;
    logic [FINE_W-1:0]  fy;
    logic [FINE_W-1:0]  fz;
    logic [VALUE_W-1:0] corr;
    logic               last;
  } fine_pt_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;    // coarse_value
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;         // fine_x, fine_y, fine_z, correction
  logic                  m_axis_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  feed_item_t coarse_feed[$];
  fine_pt_t   fine_expected[$];

  // Interpolator state
  logic [VALUE_W-1:0]    plane_mem [0:STORE_WORDS-1];
  logic [5:0]            cur_x, cur_y, cur_z;
  logic [CFG_DATA_W-1:0] span_x, span_y, span_z;

  int fail_count = 0;
  int outstanding = 0;
  int samples_in = 0;
  int gap_left, burst_left, quiet_count;
  int hold_left, window_left, rx_mode;
  logic hold_done;
  logic stim_done = 1'b0;

  always #5 clk = ~clk;

  trilinear_prolongation_stream DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  function automatic int plane_addr(input int x, input int y, input int z);
    return (((x & 1) * MAX_EXTENT + y) * MAX_EXTENT) + z;
  endfunction

  function automatic logic [FINE_W-1:0] fine_index(input logic [5:0] c, input int back);
    int f;
    f = 2 * c + 1 - back;
    return f[FINE_W-1:0];
  endfunction

  task automatic set_extent(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    logic [CFG_DATA_W-1:0] e;
    e = data;
    if (e == 0) e = CFG_DATA_W'(1);
    if (e > MAX_EXTENT) e = CFG_DATA_W'(MAX_EXTENT);
    case (idx)
      REG_EXTENT_X: span_x = e;
      REG_EXTENT_Y: span_y = e;
      REG_EXTENT_Z: span_z = e;
      default: ;
    endcase
    // any real register write restarts the region at its origin
    if (idx != REG_UNUSED) begin
      cur_x = '0;
      cur_y = '0;
      cur_z = '0;
    end
  endtask

  // Store the sample, then emit each fine point it completes, in fine raster order
  task automatic prolong_sample(input logic [VALUE_W-1:0] coarse);
    logic signed [35:0] acc;
    logic signed [35:0] mean;
    fine_pt_t pt;
    int ax, ay, az, dx, dy, dz, i, j, k;
    plane_mem[plane_addr(cur_x, cur_y, cur_z)] = coarse;
    for (ax = 0; ax < 2; ax++) begin
      dx = 1 - ax;
      if (dx == 0 || cur_x != 0) begin
        for (ay = 0; ay < 2; ay++) begin
          dy = 1 - ay;
          if (dy == 0 || cur_y != 0) begin
            for (az = 0; az < 2; az++) begin
              dz = 1 - az;
              if (dz == 0 || cur_z != 0) begin
                acc = '0;
                for (i = 0; i <= dx; i++)
                  for (j = 0; j <= dy; j++)
                    for (k = 0; k <= dz; k++)
                      acc = acc + $signed(plane_mem[plane_addr(cur_x - i, cur_y - j, cur_z - k)]);
                mean    = acc >>> (dx + dy + dz);
                pt.fx   = fine_index(cur_x, dx);
                pt.fy   = fine_index(cur_y, dy);
                pt.fz   = fine_index(cur_z, dz);
                pt.corr = mean[VALUE_W-1:0];
                // the coarse point itself always exists and always comes last
                pt.last = (dx == 0 && dy == 0 && dz == 0);
                fine_expected.insert(fine_expected.size(), pt);
              end
            end
          end
        end
      end
    end
    if ({1'b0, cur_z} + 7'd1 < span_z) cur_z = cur_z + 6'd1;
    else begin
      cur_z = '0;
      if ({1'b0, cur_y} + 7'd1 < span_y) cur_y = cur_y + 6'd1;
      else begin
        cur_y = '0;
        if ({1'b0, cur_x} + 7'd1 < span_x) cur_x = cur_x + 6'd1;
        else cur_x = '0;
      end
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, what, want, got);
      fail_count++;
    end
  endtask

  task automatic push_sample(input logic [VALUE_W-1:0] v);
    feed_item_t it;
    it.kind = FEED_SAMPLE;
    it.idx  = '0;
    it.word = v;
    coarse_feed.insert(coarse_feed.size(), it);
  endtask

  task automatic push_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    feed_item_t it;
    it.kind = FEED_REG;
    it.idx  = idx;
    it.word = {25'd0, d};
    coarse_feed.insert(coarse_feed.size(), it);
  endtask

  task automatic push_drain();
    feed_item_t it;
    it.kind = FEED_DRAIN;
    it.idx  = '0;
    it.word = '0;
    coarse_feed.insert(coarse_feed.size(), it);
  endtask

  task automatic push_region(input logic [6:0] ex, input logic [6:0] ey, input logic [6:0] ez);
    push_drain();
    push_reg(REG_EXTENT_X, ex);
    push_reg(REG_EXTENT_Y, ey);
    push_reg(REG_EXTENT_Z, ez);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: return r;
      1: begin
        case (r[1:0])
          2'd0: return 32'h7FFF_FFFF;
          2'd1: return 32'h8000_0000;
          2'd2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return {{12{r[19]}}, r[19:0]};
    endcase
  endfunction

  // Sender: bursts of words with random gaps; drain markers wait for the results
  always @(posedge clk) begin : feed_driver
    feed_item_t head;
    logic next_s, next_c;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      cfg_valid     <= 1'b0;
      cfg_index     <= '0;
      cfg_data      <= '0;
      gap_left      <= 0;
      burst_left    <= 8;
      quiet_count   <= 0;
    end else begin
      next_s = s_axis_tvalid && !s_axis_tready;
      next_c = cfg_valid && !cfg_ready;
      if (!next_s && !next_c) begin
        if (gap_left != 0) gap_left <= gap_left - 1;
        else if (coarse_feed.size() != 0) begin
          head = coarse_feed[0];
          case (head.kind)
            FEED_SAMPLE: begin
              next_s = 1'b1;
              s_axis_tdata <= head.word;
              head = coarse_feed.pop_front();
              if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 24);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
              end else burst_left <= burst_left - 1;
            end
            FEED_REG: begin
              next_c = 1'b1;
              cfg_index <= head.idx;
              cfg_data  <= head.word[CFG_DATA_W-1:0];
              head = coarse_feed.pop_front();
            end
            default: begin
              // hold until nothing is owed and the block has been quiet a while
              if (outstanding != 0) quiet_count <= 0;
              else if (quiet_count >= DRAIN_QUIET) begin
                quiet_count <= 0;
                head = coarse_feed.pop_front();
              end else quiet_count <= quiet_count + 1;
            end
          endcase
        end else stim_done <= 1'b1;
      end
      s_axis_tvalid <= next_s;
      cfg_valid     <= next_c;
    end
  end

  // Monitor: predict on every accepted word and write, check every fine point
  always @(posedge clk) begin : fine_monitor
    fine_pt_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      cur_x = '0;
      cur_y = '0;
      cur_z = '0;
      span_x = CFG_DATA_W'(MAX_EXTENT);
      span_y = CFG_DATA_W'(MAX_EXTENT);
      span_z = CFG_DATA_W'(MAX_EXTENT);
      samples_in  <= 0;
      outstanding <= 0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
      window_left <= 0;
      rx_mode     <= 0;
    end else begin
      if (cfg_valid && cfg_ready) set_extent(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) begin
        prolong_sample(s_axis_tdata);
        samples_in <= samples_in + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (fine_expected.size() == 0) begin
          $display("%0t unexpected fine point: expected none actual %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
          fail_count++;
        end else begin
          want = fine_expected.pop_front();
          check_field("fine_x", 32'(want.fx), 32'(m_axis_tdata[FX_LSB +: FINE_W]));
          check_field("fine_y", 32'(want.fy), 32'(m_axis_tdata[FY_LSB +: FINE_W]));
          check_field("fine_z", 32'(want.fz), 32'(m_axis_tdata[FZ_LSB +: FINE_W]));
          check_field("correction", want.corr, m_axis_tdata[CORR_LSB +: VALUE_W]);
          check_field("tlast", 32'(want.last), 32'(m_axis_tlast));
        end
      end
      outstanding <= fine_expected.size();

      // one long hold-off lets the block back up into its input
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && samples_in >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else begin
        if (window_left == 0) begin
          window_left <= $urandom_range(16, 96);
          rx_mode     <= $urandom_range(0, 3);
        end else window_left <= window_left - 1;
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 1);
          2: m_axis_tready <= ($urandom_range(0, 7) != 0);
          default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin : run_ctrl
    int n, ph;
    // reset extents: only z advances, so z midpoints of extreme values
    push_sample(32'h7FFF_FFFF);
    push_sample(32'h8000_0000);
    push_sample(32'h0000_0000);
    push_sample(32'hFFFF_FFFF);
    push_sample(32'h0001_0000);
    push_sample(32'h7FFF_FFFF);
    // full eight-point means at both ends of the range, wrapping to the region's origin between
    push_region(7'd2, 7'd2, 7'd2);
    for (n = 0; n < 8; n++) push_sample(32'h7FFF_FFFF);
    for (n = 0; n < 8; n++) push_sample(32'h8000_0000);

    // one long axis each: saturated, zero and exact extents drive fine indexes to the top
    push_region(7'd65, 7'd0, 7'd1);
    for (n = 0; n < 64; n++) push_sample(pick_value());
    push_region(7'd1, 7'd127, 7'd0);
    for (n = 0; n < 64; n++) push_sample(pick_value());
    push_region(7'd0, 7'd1, 7'd64);
    for (n = 0; n < 64; n++) push_sample(pick_value());

    for (ph = 0; ph < 4; ph++) begin
      push_region(7'($urandom_range(1, 5)), 7'($urandom_range(1, 5)),
                  7'($urandom_range(1, 5)));
      for (n = 0; n < 18; n++) push_sample(pick_value());
      if (ph == 1) begin
        push_drain();
        push_reg(REG_UNUSED, 7'($urandom_range(0, 127)));
      end
      for (n = 0; n < $urandom_range(12, 27); n++) push_sample(pick_value());
    end
    push_drain();

    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    wait (stim_done);
    if (fail_count == 0 && fine_expected.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tps_pkg.sv
hw/rtl/tps_ram.sv
hw/rtl/tps_front.sv
hw/rtl/tps_queue.sv
hw/rtl/tps_back.sv
hw/rtl/trilinear_prolongation_stream.sv
hw/rtl/tps_checker.sv
bench/tb_trilinear_prolongation_stream.sv
